@@ rtl/core/psc_pkg.sv @@
// Shared types and constants for the pedal sample conditioner.
// Used by psc_ring, psc_div, pedal_sample_conditioner and the testbench; depends on nothing.
package psc_pkg;

  localparam int SAMPLE_W = 12;  // converter sample and clamp bounds
  localparam int PCT_W    = 7;   // percent, threshold and pressed level
  localparam int LAST_W   = 8;   // last reported percent, holds the 255 start mark
  localparam int NUM_W    = 20;  // (raw_max - avg) * 200 + span
  localparam int DVS_W    = 13;  // divisor: sample count or twice the span

  localparam logic [SAMPLE_W-1:0] RAW_MIN_RST   = 12'd2250;
  localparam logic [SAMPLE_W-1:0] RAW_MAX_RST   = 12'd3650;
  localparam logic [PCT_W-1:0]    THRESHOLD_RST = 7'd1;
  localparam logic [PCT_W-1:0]    PRESSED_RST   = 7'd20;
  localparam logic [LAST_W-1:0]   LAST_RST      = 8'd255;
  localparam logic [PCT_W-1:0]    PCT_FULL      = 7'd100;

  typedef enum logic [1:0] {
    REG_RAW_MIN   = 2'd0,
    REG_RAW_MAX   = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_PRESSED   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic push_rd;  // fetch the oldest sample at the write position
    logic push_wr;  // store the new sample and update the running sum
  } ring_cmd_t;

endpackage

@@ rtl/core/psc_ring.sv @@
// Moving-average ring: sample memory, write position, fill flag and running sum.
// Depends on psc_pkg.
module psc_ring import psc_pkg::*; #(
  parameter int WINDOW = 20
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  ring_cmd_t                                     cmd,
  input  logic [SAMPLE_W-1:0]                           sample,
  output logic [$clog2(WINDOW*((1<<SAMPLE_W)-1)+1)-1:0] sum,
  output logic [$clog2(WINDOW+1)-1:0]                   count
);

  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                full_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SAMPLE_W-1:0] old_sample;
  logic                last_pos;

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[pos_r] <= sample;
    end
    if (cmd.push_rd) begin
      rd_data_r <= mem[pos_r];
    end
  end

  // Until the ring is full the outgoing sample counts as zero; the memory itself is not cleared.
  always_comb begin
    old_sample = full_r ? rd_data_r : '0;
    sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(sample);
    last_pos   = (pos_r == POS_W'(WINDOW - 1));
    pos_nxt    = last_pos ? '0 : pos_r + 1'b1;
    count_nxt  = full_r ? CNT_W'(WINDOW) : CNT_W'(pos_r) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else if (cmd.push_wr) begin
      pos_r   <= pos_nxt;
      full_r  <= full_r | last_pos;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  assign sum   = sum_r;
  assign count = count_r;

endmodule

@@ rtl/core/psc_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the average and
// percent steps. Depends on psc_pkg.
module psc_div import psc_pkg::*; #(
  parameter int DVD_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W:0]    shifted;
  logic              fits;

  // The partial remainder stays below the divisor, so one subtract restores it.
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? DVS_W'(shifted - {1'b0, dvs_r}) : shifted[DVS_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ rtl/core/pedal_sample_conditioner.sv @@
// Pedal sample conditioner: clamp, moving average over WINDOW samples, inverted percent.
// The result is registered after the update, average start, average wait, scale, percent
// wait and finish states, with the shared divider run twice; the next input beat can be
// taken as the result is registered. Out-of-span averages skip the second division.
// One item at a time; a stalled result holds off the next item only once it is done.
// Synchronous active-low reset clears ring sum, fill flag, sequencer and config registers.
module pedal_sample_conditioner import psc_pkg::*; #(
  parameter int WINDOW = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_raw_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PCT_W-1:0]    out_percent,
  output logic                out_report,
  output logic                out_pressed,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  localparam int DVD_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_AVG_START,
    S_AVG_WAIT,
    S_SCALE,
    S_PCT_WAIT,
    S_FINISH
  } state_t;

  // Configuration registers.
  logic [SAMPLE_W-1:0] raw_min_r, raw_max_r;
  logic [PCT_W-1:0]    threshold_r, pressed_level_r;
  reg_idx_t            cfg_idx;
  logic                cfg_wr;

  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_min_r       <= RAW_MIN_RST;
      raw_max_r       <= RAW_MAX_RST;
      threshold_r     <= THRESHOLD_RST;
      pressed_level_r <= PRESSED_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RAW_MIN:   raw_min_r       <= pwdata[SAMPLE_W-1:0];
        REG_RAW_MAX:   raw_max_r       <= pwdata[SAMPLE_W-1:0];
        REG_THRESHOLD: threshold_r     <= pwdata[PCT_W-1:0];
        REG_PRESSED:   pressed_level_r <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RAW_MIN:   prdata = 32'(raw_min_r);
      REG_RAW_MAX:   prdata = 32'(raw_max_r);
      REG_THRESHOLD: prdata = 32'(threshold_r);
      REG_PRESSED:   prdata = 32'(pressed_level_r);
      default:       prdata = '0;
    endcase
  end

  // Sequencer and datapath registers.
  state_t              state_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [PCT_W-1:0]    pct_r;
  logic [LAST_W-1:0]   last_r;
  logic                out_valid_r;
  logic [PCT_W-1:0]    out_percent_r;
  logic                out_report_r, out_pressed_r;

  logic                in_accept;
  logic [SAMPLE_W-1:0] raised, clamped;
  ring_cmd_t           ring_cmd;
  logic [SUM_W-1:0]    ring_sum;
  logic [CNT_W-1:0]    ring_count;

  logic                div_start, div_done;
  logic [DVD_W-1:0]    div_dividend, div_q;
  logic [DVS_W-1:0]    div_divisor;

  logic [SAMPLE_W-1:0] avg, span, num;
  logic [NUM_W-1:0]    num_ext, num_term;
  logic                special;
  logic [PCT_W-1:0]    special_pct;

  logic [LAST_W-1:0]   pct_ext, diff;
  logic                report, pressed, can_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // A crossed pair of bounds lands the sample on raw_max.
  always_comb begin
    raised  = (in_raw_sample < raw_min_r) ? raw_min_r : in_raw_sample;
    clamped = (raised > raw_max_r) ? raw_max_r : raised;
  end

  assign ring_cmd.push_rd = in_accept;
  assign ring_cmd.push_wr = (state_r == S_UPDATE);

  psc_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (ring_cmd),
    .sample (sample_r),
    .sum    (ring_sum),
    .count  (ring_count)
  );

  // Percent scaling: round half up of (raw_max - avg) * 100 / span, done as
  // ((raw_max - avg) * 200 + span) / (2 * span).
  always_comb begin
    avg      = div_q[SAMPLE_W-1:0];
    span     = raw_max_r - raw_min_r;
    num      = raw_max_r - avg;
    num_ext  = NUM_W'(num);
    num_term = (num_ext << 7) + (num_ext << 6) + (num_ext << 3) + NUM_W'(span);
    special  = 1'b1;
    if (raw_max_r <= raw_min_r) begin
      special_pct = '0;
    end else if (avg >= raw_max_r) begin
      special_pct = '0;
    end else if (avg <= raw_min_r) begin
      special_pct = PCT_FULL;
    end else begin
      special     = 1'b0;
      special_pct = '0;
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(num_term);
    div_divisor  = {span, 1'b0};
    case (state_r)
      S_AVG_START: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(ring_sum);
        div_divisor  = DVS_W'(ring_count);
      end
      S_SCALE: begin
        div_start = ~special;
      end
      default: ;
    endcase
  end

  psc_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    pct_ext  = LAST_W'(pct_r);
    diff     = (pct_ext >= last_r) ? pct_ext - last_r : last_r - pct_ext;
    report   = (diff >= LAST_W'(threshold_r));
    pressed  = (pct_r > pressed_level_r);
    can_load = ~out_valid_r | ~out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= LAST_RST;
    end else begin
      // In the finishing state a free output register is refilled instead.
      if (out_valid_r && !out_stall && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            sample_r <= clamped;
            state_r  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_r <= S_AVG_START;
        end
        S_AVG_START: begin
          state_r <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (special) begin
            pct_r   <= special_pct;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_PCT_WAIT;
          end
        end
        S_PCT_WAIT: begin
          if (div_done) begin
            pct_r   <= div_q[PCT_W-1:0];
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (can_load) begin
            out_valid_r   <= 1'b1;
            out_percent_r <= pct_r;
            out_report_r  <= report;
            out_pressed_r <= pressed;
            if (report) begin
              last_r <= pct_ext;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_percent = out_percent_r;
  assign out_report  = out_report_r;
  assign out_pressed = out_pressed_r;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for pedal_sample_conditioner: directed table, then random phases.
// Depends on psc_pkg and the RTL only; results come from an in-bench filter model or the table.
module testbench import psc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 20;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic             report;
    logic             pressed;
  } pedal_result_t;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    reg_idx_t         idx;
    logic [31:0]      value;
    bit               typed;
    logic [PCT_W-1:0] want_percent;
    logic             want_report;
    logic             want_pressed;
  } stim_row_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_raw_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PCT_W-1:0]    out_percent;
  logic                out_report;
  logic                out_pressed;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  pedal_sample_conditioner #(.WINDOW(RING_DEPTH)) i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_raw_sample,
    .out_valid, .out_stall, .out_percent, .out_report, .out_pressed,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Filter model state and register copies.
  logic [SAMPLE_W-1:0] ring_samples [RING_DEPTH];
  int unsigned ring_sum, ring_pos, last_pct;
  bit          ring_full;
  int unsigned bound_lo, bound_hi, report_thr, press_level;

  pedal_result_t percent_q [$];
  int errors = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  stim_row_t directed_rows [$] = '{
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd4095,  1'b1, 7'd0,  1'b1, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd0,     1'b1, 7'd50, 1'b1, 1'b1},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd2250,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd3650,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_THRESHOLD, 32'd0,     1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd2950,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd2950,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_THRESHOLD, 32'd100,   1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd0,     1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_PRESSED,   32'd0,     1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MIN,   32'd0,     1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MAX,   32'd4095,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd0,     1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd4095,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd2048,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_PRESSED,   32'd127,   1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_THRESHOLD, 32'd127,   1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MIN,   32'd4094,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd4095,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MAX,   32'd1000,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd123,   1'b1, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MIN,   32'd0,     1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd1000,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MIN,   32'd1000,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'd500,   1'b1, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MIN,   32'd2250,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_RAW_MAX,   32'd3650,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_THRESHOLD, 32'd1,     1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_WRITE,  REG_PRESSED,   32'd20,    1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'h0AAA,  1'b0, 7'd0,  1'b0, 1'b0},
    '{ROW_SAMPLE, REG_RAW_MIN,   32'h0555,  1'b0, 7'd0,  1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Clamp, push into the ring, average, map to the inverted percent scale and set report and pressed.
  function automatic pedal_result_t condition_sample(logic [SAMPLE_W-1:0] raw);
    pedal_result_t res;
    int unsigned s, count, avg, pct, span, diff;
    s = 32'(raw);
    if (s < bound_lo) s = bound_lo;
    if (s > bound_hi) s = bound_hi;
    ring_sum = ring_sum - 32'(ring_samples[ring_pos]) + s;
    ring_samples[ring_pos] = s[SAMPLE_W-1:0];
    count = ring_full ? RING_DEPTH : ring_pos + 1;
    avg = ring_sum / count;
    ring_pos++;
    if (ring_pos == RING_DEPTH) begin
      ring_pos = 0;
      ring_full = 1'b1;
    end
    if (bound_hi <= bound_lo || avg >= bound_hi) begin
      pct = 0;
    end else if (avg <= bound_lo) begin
      pct = 100;
    end else begin
      span = bound_hi - bound_lo;
      pct = ((bound_hi - avg) * 200 + span) / (2 * span);
    end
    diff = (pct >= last_pct) ? pct - last_pct : last_pct - pct;
    res.report = (diff >= report_thr);
    if (res.report) last_pct = pct;
    res.percent = pct[PCT_W-1:0];
    res.pressed = (pct > press_level);
    return res;
  endfunction

  // Called at a falling edge; leaves in_valid high so back-to-back beats stay possible.
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input bit typed,
                             input pedal_result_t typed_res);
    pedal_result_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_raw_sample = raw;
    do @(posedge clk); while (in_stall);
    res = condition_sample(raw);
    percent_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (percent_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RAW_MIN:   bound_lo = 32'(value[SAMPLE_W-1:0]);
      REG_RAW_MAX:   bound_hi = 32'(value[SAMPLE_W-1:0]);
      REG_THRESHOLD: report_thr = 32'(value[PCT_W-1:0]);
      REG_PRESSED:   press_level = 32'(value[PCT_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Receiver: random stall per cycle, plus one long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_request) begin
      hold_left = 300;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    pedal_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (percent_q.size() == 0) begin
        $error("result beat with nothing expected: percent %0d", out_percent);
        errors++;
      end else begin
        want = percent_q.pop_front();
        if (out_percent !== want.percent) begin
          $error("percent: expected %0d, got %0d", want.percent, out_percent);
          errors++;
        end
        if (out_report !== want.report) begin
          $error("report: expected %0d, got %0d", want.report, out_report);
          errors++;
        end
        if (out_pressed !== want.pressed) begin
          $error("pressed: expected %0d, got %0d", want.pressed, out_pressed);
          errors++;
        end
      end
    end
  end

  initial begin
    pedal_result_t typed_res;
    int random_items, phase, n, lo, hi, pedal_pos, step;
    logic [SAMPLE_W-1:0] raw;

    bound_lo = 32'(RAW_MIN_RST);
    bound_hi = 32'(RAW_MAX_RST);
    report_thr = 32'(THRESHOLD_RST);
    press_level = 32'(PRESSED_RST);
    foreach (ring_samples[k]) ring_samples[k] = '0;
    ring_sum = 0;
    ring_pos = 0;
    ring_full = 1'b0;
    last_pct = 32'(LAST_RST);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_drained();
        cfg_write(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        typed_res.percent = directed_rows[r].want_percent;
        typed_res.report = directed_rows[r].want_report;
        typed_res.pressed = directed_rows[r].want_pressed;
        send_sample(directed_rows[r].value[SAMPLE_W-1:0], directed_rows[r].typed, typed_res);
      end
    end

    random_items = 0;
    phase = 0;
    pedal_pos = 3000;
    typed_res = '0;
    while (random_items < 800) begin
      wait_drained();
      send_gap_pct = 0;
      stall_pct = 0;
      if (phase > 0) begin
        case ($urandom_range(9))
          0: begin lo = 0; hi = 4095; end
          1: begin lo = 4094; hi = 4095; end
          2: begin lo = $urandom_range(1, 4095); hi = $urandom_range(0, lo - 1); end
          3: begin lo = $urandom_range(4095); hi = lo; end
          default: begin
            lo = $urandom_range(3000);
            hi = $urandom_range(lo + 1, 4095);
          end
        endcase
        // Upper data bits carry noise; the registers keep only their own width.
        if ($urandom_range(3) != 0 || phase < 3)
          cfg_write(REG_RAW_MIN, {$urandom} & 32'hFFFF_F000 | lo);
        if ($urandom_range(3) != 0 || phase < 3)
          cfg_write(REG_RAW_MAX, {$urandom} & 32'hFFFF_F000 | hi);
        case ($urandom_range(7))
          0: cfg_write(REG_THRESHOLD, 32'd0);
          1: cfg_write(REG_THRESHOLD, 32'd100);
          2: cfg_write(REG_THRESHOLD, 32'd127);
          default: cfg_write(REG_THRESHOLD, {$urandom} & 32'hFFFF_FF80 | $urandom_range(1, 15));
        endcase
        case ($urandom_range(7))
          0: cfg_write(REG_PRESSED, 32'd127);
          1: cfg_write(REG_PRESSED, 32'd0);
          default: cfg_write(REG_PRESSED, $urandom_range(100));
        endcase
        case (phase % 4)
          1: send_gap_pct = 84;
          2: stall_pct = 84;
          3: begin send_gap_pct = 13; stall_pct = 13; end
          default: ;
        endcase
      end
      n = $urandom_range(40, 120);
      for (int i = 0; i < n; i++) begin
        if (phase == 0 && i == 5) hold_request = 1'b1;
        if (phase == 2 && i == n / 2) wait_drained();
        case ($urandom_range(9))
          0: raw = '0;
          1: raw = '1;
          2, 3: raw = SAMPLE_W'($urandom_range(4095));
          default: begin
            // A pedal moves smoothly, so most beats follow a bounded random walk.
            step = $urandom_range(400);
            pedal_pos = pedal_pos + step - 200;
            if (pedal_pos < 0) pedal_pos = 0;
            if (pedal_pos > 4095) pedal_pos = 4095;
            raw = pedal_pos[SAMPLE_W-1:0];
          end
        endcase
        send_sample(raw, 1'b0, typed_res);
        random_items++;
      end
      phase++;
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (percent_q.size() != 0) begin
      $error("%0d expected results never arrived", percent_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/psc_pkg.sv
rtl/core/psc_ring.sv
rtl/core/psc_div.sv
rtl/core/pedal_sample_conditioner.sv
bench/testbench.sv
